// ===== rtl/core/tmcf_pkg.sv =====
// tmcf_pkg: shared types, constants and helpers for the texture mip chain footprint block
// no dependencies; used by tmcf_ctrl, tmcf_dp and texture_mip_chain_footprint_top
package tmcf_pkg;

    localparam int MAX_DIM_LOG2 = 11;
    localparam int DIM_W        = MAX_DIM_LOG2 + 1;
    localparam int SHIFT_W      = 4;
    localparam int FLAGS_W      = 3;
    localparam int FMT_W        = 5;
    localparam int TOTAL_W      = 40;
    localparam int ACC_W        = TOTAL_W + 1;
    localparam int SUM_W        = DIM_W + 2;
    localparam int P1_W         = 2 * DIM_W;
    localparam int P2_W         = 3 * DIM_W;
    localparam int SCALE_W      = ACC_W + 3;
    localparam int HALV_W       = 4;

    localparam logic [HALV_W-1:0] MAX_HALVINGS = 4'd13;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

    // image flag bit positions
    localparam int FLAG_FULL_SIZE = 0;
    localparam int FLAG_SINGLE    = 1;
    localparam int FLAG_CUBE      = 2;

    // format code boundaries
    localparam logic [FMT_W-1:0] FMT_BC_8B_LAST   = 5'd0;
    localparam logic [FMT_W-1:0] FMT_BC_16B_LAST  = 5'd2;
    localparam logic [FMT_W-1:0] FMT_TEX_8B_LAST  = 5'd4;
    localparam logic [FMT_W-1:0] FMT_TEX_4B_LAST  = 5'd11;
    localparam logic [FMT_W-1:0] FMT_TEX_2B_LAST  = 5'd14;
    localparam logic [FMT_W-1:0] FMT_TEX_1B_LAST  = 5'd16;

    typedef struct packed {
        logic       known;
        logic       blk;
        logic [2:0] shamt;
    } t_fmt_info;

    typedef struct packed {
        logic load;
        logic issue;
        logic halve;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic single;
    } t_dp_sts;

    function automatic t_fmt_info f_fmt_decode(input logic [FMT_W-1:0] fmt);
        t_fmt_info fi;
        fi = '{known: 1'b1, blk: 1'b0, shamt: 3'd0};
        if (fmt <= FMT_BC_8B_LAST) begin
            fi.blk   = 1'b1;
            fi.shamt = 3'd3;
        end else if (fmt <= FMT_BC_16B_LAST) begin
            fi.blk   = 1'b1;
            fi.shamt = 3'd4;
        end else if (fmt <= FMT_TEX_8B_LAST) begin
            fi.shamt = 3'd3;
        end else if (fmt <= FMT_TEX_4B_LAST) begin
            fi.shamt = 3'd2;
        end else if (fmt <= FMT_TEX_2B_LAST) begin
            fi.shamt = 3'd1;
        end else if (fmt <= FMT_TEX_1B_LAST) begin
            fi.shamt = 3'd0;
        end else begin
            fi.known = 1'b0;
        end
        return fi;
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp1(input logic [DIM_W-1:0] v);
        return (v == '0) ? DIM_W'(1) : v;
    endfunction

endpackage

// ===== rtl/core/texture_mip_chain_footprint_top.sv =====
// texture_mip_chain_footprint_top: memory footprint of a texture and its mip chain
// depends on tmcf_pkg, tmcf_ctrl and tmcf_dp
//
// slave stream: one texture description per transfer; tuser carries flags and format,
// tdata carries width, height, depth and picmip shift
// master stream: one 40-bit byte count per texture, saturated at 2^40 - 1
// one texture is processed at a time; the slave side is ready only while the
// sequencer is idle
// the sequencer issues one mip level per cycle into a two-stage multiplier
// (width x height, then x depth) followed by the accumulator
// each item: load, one issue per mip level (1 to 12 levels), multiplier drain, then
// the cube scaling and saturation step that writes the result register
// the result sits in an output register: the next texture is taken while it waits
// if the receiver stalls with a result pending, the next texture finishes and
// holds in its last step until the pending result is taken
// reset (synchronous, active low) drops the master tvalid and returns to idle
module texture_mip_chain_footprint_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // base_width, base_height, base_depth, picmip_shift
    input  logic [7:0]  i_s_axis_tuser,   // image_flags, texel_format
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // total_bytes
);

    tmcf_pkg::t_dp_cmd w_cmd;
    tmcf_pkg::t_dp_sts w_sts;

    tmcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tmcf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_flags  (i_s_axis_tuser[2:0]),
        .i_fmt    (i_s_axis_tuser[7:3]),
        .i_width  (i_s_axis_tdata[11:0]),
        .i_height (i_s_axis_tdata[23:12]),
        .i_depth  (i_s_axis_tdata[35:24]),
        .i_shift  (i_s_axis_tdata[39:36]),
        .o_total  (o_m_axis_tdata)
    );

endmodule

// ===== rtl/core/tmcf_ctrl.sv =====
// tmcf_ctrl: sequencer for one texture item: load, per-level issue, pipeline drain, result
// depends on tmcf_pkg (command and status structs, halving limit)
module tmcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tmcf_pkg::t_dp_sts i_sts,
    output tmcf_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [tmcf_pkg::HALV_W-1:0] r_halv, n_halv;
    logic                        r_drain, n_drain;
    logic                        r_out_valid, n_out_valid;
    logic                        w_more;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_more      = i_sts.more && !i_sts.single && (r_halv != tmcf_pkg::MAX_HALVINGS);

    always_comb begin
        n_state     = r_state;
        n_halv      = r_halv;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_halv     = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (w_more) begin
                    o_cmd.halve = 1'b1;
                    n_halv      = r_halv + 1'b1;
                end else begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_halv      <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_halv      <= n_halv;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/tmcf_dp.sv =====
// tmcf_dp: dimension registers, two-stage level-size multiplier, accumulator, cube scaling
// depends on tmcf_pkg (widths, format decode, clamp helper, command and status structs)
module tmcf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tmcf_pkg::t_dp_cmd              i_cmd,
    output tmcf_pkg::t_dp_sts              o_sts,
    input  logic [tmcf_pkg::FLAGS_W-1:0]   i_flags,
    input  logic [tmcf_pkg::FMT_W-1:0]     i_fmt,
    input  logic [tmcf_pkg::DIM_W-1:0]     i_width,
    input  logic [tmcf_pkg::DIM_W-1:0]     i_height,
    input  logic [tmcf_pkg::DIM_W-1:0]     i_depth,
    input  logic [tmcf_pkg::SHIFT_W-1:0]   i_shift,
    output logic [tmcf_pkg::TOTAL_W-1:0]   o_total
);

    localparam int DW = tmcf_pkg::DIM_W;

    logic [tmcf_pkg::FLAGS_W-1:0] r_flags;
    logic [tmcf_pkg::FMT_W-1:0]   r_fmt;
    logic [DW-1:0]                r_w, r_h, r_d;
    logic [tmcf_pkg::P1_W-1:0]    r_p1;
    logic [DW-1:0]                r_c1;
    logic                         r_v1;
    logic [tmcf_pkg::P2_W-1:0]    r_p2;
    logic                         r_v2;
    logic [tmcf_pkg::ACC_W-1:0]   r_acc;
    logic [tmcf_pkg::TOTAL_W-1:0] r_total;

    tmcf_pkg::t_fmt_info          w_fi;
    logic [DW:0]                  w_wr, w_hr;
    logic [DW-1:0]                w_a, w_b;
    logic [tmcf_pkg::SUM_W-1:0]   w_sum;
    logic [tmcf_pkg::TOTAL_W-1:0] w_level;
    logic [tmcf_pkg::SCALE_W-1:0] w_scaled;

    assign w_fi  = tmcf_pkg::f_fmt_decode(r_fmt);
    assign w_wr  = {1'b0, r_w} + (DW+1)'(3);
    assign w_hr  = {1'b0, r_h} + (DW+1)'(3);
    assign w_a   = w_fi.blk ? DW'(w_wr >> 2) : r_w;
    assign w_b   = w_fi.blk ? DW'(w_hr >> 2) : r_h;
    assign w_sum = tmcf_pkg::SUM_W'(r_w) + tmcf_pkg::SUM_W'(r_h) + tmcf_pkg::SUM_W'(r_d);

    assign w_level  = w_fi.known ? (tmcf_pkg::TOTAL_W'(r_p2) << w_fi.shamt) : '0;
    assign w_scaled = r_flags[tmcf_pkg::FLAG_CUBE]
                    ? ((tmcf_pkg::SCALE_W'(r_acc) << 2) + (tmcf_pkg::SCALE_W'(r_acc) << 1))
                    : tmcf_pkg::SCALE_W'(r_acc);

    assign o_sts.more   = (w_sum > tmcf_pkg::SUM_W'(3));
    assign o_sts.single = r_flags[tmcf_pkg::FLAG_SINGLE];
    assign o_total      = r_total;

    // item load and per-level halving
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flags <= i_flags;
            r_fmt   <= i_fmt;
            if (i_flags[tmcf_pkg::FLAG_FULL_SIZE]) begin
                r_w <= i_width;
                r_h <= i_height;
                r_d <= i_depth;
            end else begin
                r_w <= tmcf_pkg::f_clamp1(i_width >> i_shift);
                r_h <= tmcf_pkg::f_clamp1(i_height >> i_shift);
                r_d <= tmcf_pkg::f_clamp1(i_depth >> i_shift);
            end
        end else if (i_cmd.halve) begin
            r_w <= tmcf_pkg::f_clamp1(r_w >> 1);
            r_h <= tmcf_pkg::f_clamp1(r_h >> 1);
            r_d <= tmcf_pkg::f_clamp1(r_d >> 1);
        end
    end

    // level size pipeline: width x height, then x depth, then accumulate
    always_ff @(posedge i_clk) begin
        r_p1 <= w_a * w_b;
        r_c1 <= r_d;
        r_p2 <= r_p1 * tmcf_pkg::P1_W'(r_c1);
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + tmcf_pkg::ACC_W'(w_level);
        end
        if (i_cmd.finish) begin
            r_total <= (w_scaled > tmcf_pkg::SCALE_W'(tmcf_pkg::TOTAL_MAX))
                     ? tmcf_pkg::TOTAL_MAX : w_scaled[tmcf_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

endmodule

// ===== rtl/core/tmcf_checker.sv =====
// tmcf_checker: port-level assertions for texture_mip_chain_footprint_top
// bound to the top level; no package dependency
module tmcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    // a pending result holds until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one texture in flight: no second input right after a transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");

    // a new result only appears at the end of processing
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind texture_mip_chain_footprint_top tmcf_checker u_tmcf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/texture_footprint_checker.sv =====
// texture_footprint_checker: watches both streams of the mip chain footprint block,
// predicts the byte count of each accepted texture and compares it with the result stream
// depends on tmcf_pkg for field widths, flag positions and format boundaries
`timescale 1ns / 1ps

module texture_footprint_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [39:0]            i_s_axis_tdata,   // base_width, base_height, base_depth, picmip_shift
    input  logic [7:0]             i_s_axis_tuser,   // image_flags, texel_format
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [39:0]            i_m_axis_tdata,   // total_bytes
    output int                     o_errors,
    output int                     o_outstanding
);

    logic [tmcf_pkg::TOTAL_W-1:0] expected_totals[$];
    int                           error_count = 0;

    assign o_errors = error_count;

    task automatic flag_error(input string what, input logic [tmcf_pkg::TOTAL_W-1:0] got,
                              input logic [tmcf_pkg::TOTAL_W-1:0] want);
        $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint unsigned at_least_one(input longint unsigned v);
        return (v > 1) ? v : 1;
    endfunction

    function automatic longint unsigned level_size(input logic [tmcf_pkg::FMT_W-1:0] fmt,
                                                   input longint unsigned w,
                                                   input longint unsigned h,
                                                   input longint unsigned d);
        longint unsigned blocks;
        longint unsigned texels;
        blocks = ((w + 3) >> 2) * ((h + 3) >> 2) * d;
        texels = w * h * d;
        if (fmt <= tmcf_pkg::FMT_BC_8B_LAST)  return 8 * blocks;
        if (fmt <= tmcf_pkg::FMT_BC_16B_LAST) return 16 * blocks;
        if (fmt <= tmcf_pkg::FMT_TEX_8B_LAST) return 8 * texels;
        if (fmt <= tmcf_pkg::FMT_TEX_4B_LAST) return 4 * texels;
        if (fmt <= tmcf_pkg::FMT_TEX_2B_LAST) return 2 * texels;
        if (fmt <= tmcf_pkg::FMT_TEX_1B_LAST) return texels;
        return 0;
    endfunction

    function automatic logic [tmcf_pkg::TOTAL_W-1:0] footprint_bytes(
        input logic [tmcf_pkg::FLAGS_W-1:0] flags,
        input logic [tmcf_pkg::FMT_W-1:0]   fmt,
        input logic [tmcf_pkg::DIM_W-1:0]   base_w,
        input logic [tmcf_pkg::DIM_W-1:0]   base_h,
        input logic [tmcf_pkg::DIM_W-1:0]   base_d,
        input logic [tmcf_pkg::SHIFT_W-1:0] shamt);
        longint unsigned w;
        longint unsigned h;
        longint unsigned d;
        longint unsigned total;
        int              n;
        w = base_w;
        h = base_h;
        d = base_d;
        if (!flags[tmcf_pkg::FLAG_FULL_SIZE]) begin
            w = at_least_one(w >> shamt);
            h = at_least_one(h >> shamt);
            d = at_least_one(d >> shamt);
        end
        total = level_size(fmt, w, h, d);
        if (!flags[tmcf_pkg::FLAG_SINGLE]) begin
            for (n = 0; n < tmcf_pkg::MAX_HALVINGS && (w + h + d) > 3; n++) begin
                w = at_least_one(w >> 1);
                h = at_least_one(h >> 1);
                d = at_least_one(d >> 1);
                total += level_size(fmt, w, h, d);
            end
        end
        if (flags[tmcf_pkg::FLAG_CUBE]) total = total * 6;
        if (total > tmcf_pkg::TOTAL_MAX) total = tmcf_pkg::TOTAL_MAX;
        return total[tmcf_pkg::TOTAL_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [tmcf_pkg::TOTAL_W-1:0] want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_totals.push_back(footprint_bytes(
                    i_s_axis_tuser[tmcf_pkg::FLAGS_W-1:0],
                    i_s_axis_tuser[tmcf_pkg::FLAGS_W+tmcf_pkg::FMT_W-1:tmcf_pkg::FLAGS_W],
                    i_s_axis_tdata[tmcf_pkg::DIM_W-1:0],
                    i_s_axis_tdata[2*tmcf_pkg::DIM_W-1:tmcf_pkg::DIM_W],
                    i_s_axis_tdata[3*tmcf_pkg::DIM_W-1:2*tmcf_pkg::DIM_W],
                    i_s_axis_tdata[3*tmcf_pkg::DIM_W+tmcf_pkg::SHIFT_W-1:3*tmcf_pkg::DIM_W]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_totals.size() == 0) begin
                    flag_error("result with no texture pending", i_m_axis_tdata, '0);
                end else begin
                    want = expected_totals.pop_front();
                    if (i_m_axis_tdata !== want)
                        flag_error("total_bytes", i_m_axis_tdata, want);
                end
            end
        end
        o_outstanding <= expected_totals.size();
    end

endmodule

// ===== sim/tb_texture_mip_chain_footprint_top.sv =====
// tb_texture_mip_chain_footprint_top: drives texture descriptions into the footprint block
// with random gaps and result-side stalls, and gives the verdict from the checker's count
// depends on tmcf_pkg, texture_mip_chain_footprint_top and texture_footprint_checker
`timescale 1ns / 1ps

module tb_texture_mip_chain_footprint_top;

    localparam int RUN_LIMIT    = 1000000;
    localparam int RANDOM_ITEMS = 1800;

    localparam logic [tmcf_pkg::FLAGS_W-1:0] F_NONE   = '0;
    localparam logic [tmcf_pkg::FLAGS_W-1:0] F_FULL   =
        tmcf_pkg::FLAGS_W'(1) << tmcf_pkg::FLAG_FULL_SIZE;
    localparam logic [tmcf_pkg::FLAGS_W-1:0] F_SINGLE =
        tmcf_pkg::FLAGS_W'(1) << tmcf_pkg::FLAG_SINGLE;
    localparam logic [tmcf_pkg::FLAGS_W-1:0] F_CUBE   =
        tmcf_pkg::FLAGS_W'(1) << tmcf_pkg::FLAG_CUBE;

    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_BC16_FIRST = tmcf_pkg::FMT_BC_8B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_TEX8_FIRST = tmcf_pkg::FMT_BC_16B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_TEX4_FIRST = tmcf_pkg::FMT_TEX_8B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_TEX2_FIRST = tmcf_pkg::FMT_TEX_4B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_TEX1_FIRST = tmcf_pkg::FMT_TEX_2B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_UNKNOWN    = tmcf_pkg::FMT_TEX_1B_LAST + 5'd1;
    localparam logic [tmcf_pkg::FMT_W-1:0] FMT_TOP_CODE   = '1;

    localparam logic [tmcf_pkg::DIM_W-1:0]   DIM_ALL   = '1;
    localparam logic [tmcf_pkg::SHIFT_W-1:0] SHIFT_ALL = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // base_width, base_height, base_depth, picmip_shift
    logic [7:0]  s_tuser = '0;    // image_flags, texel_format
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // total_bytes
    int          errors;
    int          outstanding;
    int          cycles = 0;

    texture_mip_chain_footprint_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    texture_footprint_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_errors        (errors),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [tmcf_pkg::DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 1))
            return tmcf_pkg::DIM_W'(1) << $urandom_range(0, tmcf_pkg::MAX_DIM_LOG2);
        return tmcf_pkg::DIM_W'($urandom_range(1, 1 << tmcf_pkg::MAX_DIM_LOG2));
    endfunction

    task automatic send_texture(input logic [tmcf_pkg::FLAGS_W-1:0] flags,
                                input logic [tmcf_pkg::FMT_W-1:0]   fmt,
                                input logic [tmcf_pkg::DIM_W-1:0]   w,
                                input logic [tmcf_pkg::DIM_W-1:0]   h,
                                input logic [tmcf_pkg::DIM_W-1:0]   d,
                                input logic [tmcf_pkg::SHIFT_W-1:0] shamt);
        int gap;
        s_tuser  <= {fmt, flags};
        s_tdata  <= {shamt, d, h, w};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: ready stretches broken by stalls of random length
    initial begin
        int on_len;
        forever begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            m_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge i_clk);
        end
    end

    initial begin
        int                           k;
        int                           r;
        logic [tmcf_pkg::FLAGS_W-1:0] flags;
        logic [tmcf_pkg::FMT_W-1:0]   fmt;
        logic [tmcf_pkg::DIM_W-1:0]   w;
        logic [tmcf_pkg::DIM_W-1:0]   h;
        logic [tmcf_pkg::DIM_W-1:0]   d;
        logic [tmcf_pkg::SHIFT_W-1:0] shamt;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_texture(F_NONE, tmcf_pkg::FMT_BC_8B_LAST, 12'd1, 12'd1, 12'd1, 4'd0);
        send_texture(F_NONE, FMT_BC16_FIRST, 12'd2048, 12'd2048, 12'd1, 4'd0);
        send_texture(F_NONE, tmcf_pkg::FMT_BC_16B_LAST, 12'd256, 12'd128, 12'd1, 4'd0);
        send_texture(F_NONE, FMT_TEX8_FIRST, 12'd64, 12'd64, 12'd64, 4'd0);
        send_texture(F_NONE, FMT_TEX4_FIRST, 12'd2048, 12'd1, 12'd1, 4'd0);
        send_texture(F_NONE, FMT_TEX2_FIRST, 12'd1, 12'd2048, 12'd1, 4'd0);
        send_texture(F_NONE, FMT_TEX1_FIRST, 12'd1, 12'd1, 12'd2048, 4'd0);
        send_texture(F_NONE, tmcf_pkg::FMT_TEX_1B_LAST, 12'd37, 12'd91, 12'd5, 4'd0);
        send_texture(F_NONE, FMT_UNKNOWN, 12'd512, 12'd512, 12'd1, 4'd0);
        send_texture(F_NONE, FMT_TOP_CODE, DIM_ALL, DIM_ALL, DIM_ALL, SHIFT_ALL);
        // zero dimensions kept at full size, clamped otherwise
        send_texture(F_FULL, tmcf_pkg::FMT_TEX_4B_LAST, 12'd0, 12'd0, 12'd0, 4'd5);
        send_texture(F_FULL, tmcf_pkg::FMT_BC_8B_LAST, 12'd0, 12'd64, 12'd1, 4'd3);
        send_texture(F_NONE, FMT_TEX4_FIRST, 12'd0, 12'd0, 12'd0, 4'd0);
        send_texture(F_SINGLE, tmcf_pkg::FMT_TEX_4B_LAST, 12'd300, 12'd200, 12'd1, 4'd0);
        send_texture(F_CUBE, tmcf_pkg::FMT_BC_8B_LAST, 12'd128, 12'd128, 12'd1, 4'd0);
        send_texture(F_FULL | F_SINGLE | F_CUBE, tmcf_pkg::FMT_BC_16B_LAST,
                     DIM_ALL, DIM_ALL, 12'd1, 4'd0);
        // large totals; a cube total past the 40-bit range saturates
        send_texture(F_FULL, FMT_TEX8_FIRST, DIM_ALL, DIM_ALL, DIM_ALL, 4'd0);
        send_texture(F_CUBE, tmcf_pkg::FMT_TEX_8B_LAST, DIM_ALL, DIM_ALL, DIM_ALL, 4'd0);
        send_texture(F_NONE, tmcf_pkg::FMT_TEX_4B_LAST, 12'd2048, 12'd2048, 12'd2048, 4'd11);
        send_texture(F_NONE, tmcf_pkg::FMT_TEX_2B_LAST, 12'd2048, 12'd1024, 12'd16, SHIFT_ALL);
        send_texture(F_FULL | F_SINGLE, tmcf_pkg::FMT_TEX_2B_LAST,
                     DIM_ALL, 12'd1, 12'd1, SHIFT_ALL);
        send_texture(F_SINGLE | F_CUBE, tmcf_pkg::FMT_TEX_4B_LAST,
                     12'd1000, 12'd1000, 12'd1, 4'd2);
        send_texture(F_FULL | F_CUBE, tmcf_pkg::FMT_TEX_8B_LAST, 12'd2, 12'd3, DIM_ALL, 4'd1);
        send_texture(F_SINGLE, tmcf_pkg::FMT_BC_8B_LAST, 12'd5, 12'd7, 12'd3, 4'd9);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 600 == 300) begin
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (outstanding != 0);
            end
            r     = $urandom_range(0, 99);
            flags = tmcf_pkg::FLAGS_W'($urandom_range(0, 7));
            if (r < 70) begin
                fmt   = tmcf_pkg::FMT_W'($urandom_range(0, tmcf_pkg::FMT_TEX_1B_LAST));
                w     = pick_dim();
                h     = pick_dim();
                d     = $urandom_range(0, 1) ? tmcf_pkg::DIM_W'(1) : pick_dim();
                shamt = $urandom_range(0, 1) ? '0
                      : tmcf_pkg::SHIFT_W'($urandom_range(0, tmcf_pkg::MAX_DIM_LOG2));
            end else begin
                fmt   = tmcf_pkg::FMT_W'($urandom_range(0, 31));
                w     = tmcf_pkg::DIM_W'($urandom);
                h     = tmcf_pkg::DIM_W'($urandom);
                d     = tmcf_pkg::DIM_W'($urandom);
                shamt = tmcf_pkg::SHIFT_W'($urandom);
            end
            send_texture(flags, fmt, w, h, d, shamt);
        end

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
